FILE: hdl/positional_array_list_assert.svh
// assertion macros for positional_array_list.sv
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// condition holds in the same cycle
`define PAL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the next cycle
`define PAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/plal_pkg.sv
package plal_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int CMD_W = 3;
	localparam int POS_W = 7;
	localparam int VAL_W = 32;
	localparam int STAT_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// what every cell does this cycle
	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_LOAD = 2'd1,
		OP_INS  = 2'd2,
		OP_DEL  = 2'd3
	} cell_op_t;

	// broadcast from the controller to all cells
	typedef struct packed {
		cell_op_t         op;
		logic [POS_W-1:0] target;
		logic [POS_W-1:0] len;
		logic [VAL_W-1:0] value;
	} cell_ctrl_t;

endpackage

FILE: hdl/plal_cell.sv
module plal_cell #(
	parameter int IDX = 0
) (
	input  logic                           clk,
	input  plal_pkg::cell_ctrl_t           ctrl,
	input  logic [plal_pkg::VAL_W-1:0]     prev_entry,
	input  logic [plal_pkg::VAL_W-1:0]     next_entry,
	output logic [plal_pkg::VAL_W-1:0]     entry,
	output logic                           match,
	output logic [plal_pkg::VAL_W-1:0]     rd_data
);

	localparam logic [plal_pkg::POS_W-1:0] MY_IDX = plal_pkg::POS_W'(IDX);

	logic [plal_pkg::VAL_W-1:0] entry_q;
	logic                       at_target;
	logic                       past_target;

	assign at_target   = (MY_IDX == ctrl.target);
	assign past_target = (MY_IDX > ctrl.target);

	// entry update: load, open a gap, or close one
	always_ff @(posedge clk) begin
		case (ctrl.op)
			plal_pkg::OP_HOLD: begin
				entry_q <= entry_q;
			end
			plal_pkg::OP_LOAD: begin
				if (at_target) begin
					entry_q <= ctrl.value;
				end
			end
			plal_pkg::OP_INS: begin
				if (past_target) begin
					entry_q <= prev_entry;
				end else if (at_target) begin
					entry_q <= ctrl.value;
				end
			end
			plal_pkg::OP_DEL: begin
				if (past_target || at_target) begin
					entry_q <= next_entry;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry = entry_q;

	// compare only live entries
	assign match = (MY_IDX < ctrl.len) && (entry_q == ctrl.value);

	// read contribution, or-ed over the row
	assign rd_data = at_target ? entry_q : '0;

endmodule

FILE: hdl/positional_array_list.sv
// channel | direction | tdata                                   | tuser
// s_*     | in        | position[6:0] value[38:7] (40 bits)     | cmd[2:0]
// m_*     | out       | status[1:0] found[2] found_position[9:3]|
//         |           | read_value[41:10] count[48:42] (56 bits)| none
//
// a result word is offered once it has passed the accept register, the second stage,
// where the row of cells shifts, loads and compares in parallel, and the first-match
// encode into the output register. a new word is taken once the previous one is in the
// output register.
// arst_n clears the count and valid flags; entries are undefined until written.
// a stalled result holds in the output register and the next command waits behind it.
module positional_array_list #(
	parameter int CAPACITY = plal_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // position[6:0], value[38:7], zero pad
	input  logic [2:0]  s_tuser,   // cmd[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // status, found, found_position, read_value, count
);

	`include "positional_array_list_assert.svh"

	localparam int PW = plal_pkg::POS_W;
	localparam int VW = plal_pkg::VAL_W;
	localparam logic [PW-1:0] CAP_LEN = PW'(CAPACITY);

	// first stage: accepted command
	logic                       v_s1;
	logic [plal_pkg::CMD_W-1:0] cmd_s1;
	logic [PW-1:0]              pos_s1;
	logic [VW-1:0]              val_s1;

	// second stage: command outcome and match flags
	logic                       v_s2;
	logic [plal_pkg::STAT_W-1:0] status_s2;
	logic                       is_search_s2;
	logic [CAPACITY-1:0]        match_s2;
	logic [VW-1:0]              rval_s2;
	logic [PW-1:0]              count_s2;

	// output register
	logic                       out_valid_q;
	logic [plal_pkg::STAT_W-1:0] out_status_q;
	logic                       out_found_q;
	logic [PW-1:0]              out_fpos_q;
	logic [VW-1:0]              out_rval_q;
	logic [PW-1:0]              out_count_q;

	logic [PW-1:0]              len_q;

	logic                       in_fire;
	logic                       s2_move;
	logic                       full;
	logic                       pos_ok;
	logic                       pos_ok_ins;
	logic [PW-1:0]              len_next;
	logic [plal_pkg::STAT_W-1:0] status_c;
	plal_pkg::cell_ctrl_t       ctrl;

	logic [VW-1:0]              entry_w [CAPACITY];
	logic [VW-1:0]              rd_w    [CAPACITY];
	logic [CAPACITY-1:0]        match_w;
	logic [VW-1:0]              rd_or;

	logic [CAPACITY-1:0]        first_hot;
	logic                       found_c;
	logic [PW-1:0]              fpos_c;

	assign in_fire  = s_tvalid && s_tready;
	assign s_tready = !v_s1 && !v_s2;
	assign s2_move  = v_s2 && (!out_valid_q || m_tready);

	// accept stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1 <= s_tuser;
			pos_s1 <= s_tdata[6:0];
			val_s1 <= s_tdata[38:7];
		end
	end

	// command decode against the current count
	assign full       = (len_q >= CAP_LEN);
	assign pos_ok     = (pos_s1 != '0) && (pos_s1 <= len_q);
	assign pos_ok_ins = (pos_s1 != '0) && (pos_s1 <= len_q + PW'(1));

	always_comb begin
		ctrl.op     = plal_pkg::OP_HOLD;
		ctrl.target = pos_s1 - PW'(1);
		ctrl.len    = len_q;
		ctrl.value  = val_s1;
		len_next    = len_q;
		status_c    = plal_pkg::ST_OK;
		case (cmd_s1)
			plal_pkg::CMD_CLEAR: begin
				len_next = '0;
			end
			plal_pkg::CMD_APPEND: begin
				ctrl.target = len_q;
				if (full) begin
					status_c = plal_pkg::ST_FULL;
				end else begin
					ctrl.op  = plal_pkg::OP_LOAD;
					len_next = len_q + PW'(1);
				end
			end
			plal_pkg::CMD_INSERT: begin
				if (full) begin
					status_c = plal_pkg::ST_FULL;
				end else if (!pos_ok_ins) begin
					status_c = plal_pkg::ST_RANGE;
				end else begin
					ctrl.op  = plal_pkg::OP_INS;
					len_next = len_q + PW'(1);
				end
			end
			plal_pkg::CMD_DELETE: begin
				if (!pos_ok) begin
					status_c = plal_pkg::ST_RANGE;
				end else begin
					ctrl.op  = plal_pkg::OP_DEL;
					len_next = len_q - PW'(1);
				end
			end
			plal_pkg::CMD_READ: begin
				if (!pos_ok) begin
					status_c = plal_pkg::ST_RANGE;
				end
			end
			default: begin
				status_c = plal_pkg::ST_OK;
			end
		endcase
		if (!v_s1) begin
			ctrl.op  = plal_pkg::OP_HOLD;
			len_next = len_q;
		end
	end

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VW-1:0] prev_w;
		logic [VW-1:0] next_w;
		if (i == 0) begin : g_first
			assign prev_w = val_s1;
		end else begin : g_mid_lo
			assign prev_w = entry_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_w = entry_w[i];
		end else begin : g_mid_hi
			assign next_w = entry_w[i+1];
		end
		plal_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.prev_entry (prev_w),
			.next_entry (next_w),
			.entry      (entry_w[i]),
			.match      (match_w[i]),
			.rd_data    (rd_w[i])
		);
	end

	// read data gathered over the row
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | rd_w[i];
		end
	end

	// count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else begin
			len_q <= len_next;
		end
	end

	// second stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (v_s1) begin
			v_s2 <= 1'b1;
		end else if (s2_move) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			status_s2    <= status_c;
			is_search_s2 <= (cmd_s1 == plal_pkg::CMD_SEARCH);
			match_s2     <= match_w;
			rval_s2      <= (cmd_s1 == plal_pkg::CMD_READ && pos_ok) ? rd_or : '0;
			count_s2     <= len_next;
		end
	end

	// first match: isolate lowest set flag, then encode
	assign first_hot = match_s2 & (~match_s2 + CAPACITY'(1));
	assign found_c   = is_search_s2 && (match_s2 != '0);

	always_comb begin
		fpos_c = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_hot[i]) begin
				fpos_c = fpos_c | PW'(i + 1);
			end
		end
		if (!is_search_s2) begin
			fpos_c = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_move) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			out_status_q <= status_s2;
			out_found_q  <= found_c;
			out_fpos_q   <= fpos_c;
			out_rval_q   <= rval_s2;
			out_count_q  <= count_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_count_q, out_rval_q, out_fpos_q, out_found_q, out_status_q};

	// checks
	`PAL_ASSERT_SAME(a_len_cap, clk, arst_n, 1'b1, len_q <= CAP_LEN, "count above capacity")
	`PAL_ASSERT_NEXT(a_len_quiet, clk, arst_n, !v_s1, $stable(len_q), "count moved with no command")
	`PAL_ASSERT_NEXT(a_s1_to_s2, clk, arst_n, v_s1, v_s2, "command lost after first stage")
	`PAL_ASSERT_SAME(a_found_pos, clk, arst_n, out_valid_q,
		out_found_q == (out_fpos_q != '0), "found flag and position disagree")

endmodule

FILE: dv/positional_array_list_test.sv
`timescale 1ns / 100ps

module positional_array_list_test;

	localparam int LIST_DEPTH = plal_pkg::CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_WORDS = 1500;
	localparam int HOLD_AT_WORD = 700;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 10;

	// command codes the block ignores
	localparam logic [plal_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [plal_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	// traffic shapes for the random part
	localparam int MODE_GROW = 0;
	localparam int MODE_SHRINK = 1;
	localparam int MODE_MIXED = 2;
	localparam int MODE_QUERY = 3;

	// receiver stall patterns
	localparam int RDY_ALWAYS = 0;
	localparam int RDY_HALF = 1;
	localparam int RDY_SPARSE = 2;
	localparam int RDY_DENSE = 3;

	typedef struct {
		logic [plal_pkg::CMD_W-1:0] cmd;
		logic [plal_pkg::POS_W-1:0] position;
		logic [plal_pkg::VAL_W-1:0] value;
		bit                         wait_idle;
	} list_cmd_t;

	typedef struct packed {
		logic [plal_pkg::STAT_W-1:0] status;
		logic                        found;
		logic [plal_pkg::POS_W-1:0]  found_position;
		logic [plal_pkg::VAL_W-1:0]  read_value;
		logic [plal_pkg::POS_W-1:0]  count;
	} list_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // position[6:0], value[38:7], zero pad
	logic [2:0]  s_tuser = '0;   // cmd[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;        // status, found, found_position, read_value, count

	positional_array_list DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	list_cmd_t   queued_cmds[$];
	list_reply_t predicted_replies[$];
	logic [plal_pkg::VAL_W-1:0] recent_values[$];

	// shadow copy of the list
	logic [plal_pkg::VAL_W-1:0] list_mem [LIST_DEPTH];
	int unsigned                list_len = 0;

	// list length as the stimulus generator sees it
	int unsigned gen_len = 0;

	int words_in = 0;
	int words_seen = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int ready_mode = RDY_ALWAYS;
	int segment_left = 0;

	// carry out one command on the shadow list and return its reply
	function automatic list_reply_t apply_list_cmd(logic [plal_pkg::CMD_W-1:0] cmd,
			logic [plal_pkg::POS_W-1:0] position, logic [plal_pkg::VAL_W-1:0] value);
		list_reply_t r;
		int unsigned i;
		bit hit;
		r = '0;
		hit = 1'b0;
		case (cmd)
			plal_pkg::CMD_CLEAR: list_len = 0;
			plal_pkg::CMD_APPEND: begin
				if (list_len >= LIST_DEPTH) r.status = plal_pkg::ST_FULL;
				else begin
					list_mem[list_len] = value;
					list_len++;
				end
			end
			plal_pkg::CMD_INSERT: begin
				if (list_len >= LIST_DEPTH) r.status = plal_pkg::ST_FULL;
				else if (position < 1 || position > list_len + 1)
					r.status = plal_pkg::ST_RANGE;
				else begin
					for (i = list_len; i >= position; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[position-1] = value;
					list_len++;
				end
			end
			plal_pkg::CMD_DELETE: begin
				if (position < 1 || position > list_len) r.status = plal_pkg::ST_RANGE;
				else begin
					for (i = position - 1; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			plal_pkg::CMD_SEARCH: begin
				// first match wins
				for (i = 0; i < list_len; i++) begin
					if (!hit && list_mem[i] == value) begin
						hit = 1'b1;
						r.found = 1'b1;
						r.found_position = plal_pkg::POS_W'(i + 1);
					end
				end
			end
			plal_pkg::CMD_READ: begin
				if (position < 1 || position > list_len) r.status = plal_pkg::ST_RANGE;
				else r.read_value = list_mem[position-1];
			end
			default: ;
		endcase
		r.count = plal_pkg::POS_W'(list_len);
		return r;
	endfunction

	// queue one command and follow the list length it leaves behind
	function automatic void queue_cmd(logic [plal_pkg::CMD_W-1:0] cmd, int position,
			logic [plal_pkg::VAL_W-1:0] value, bit wait_idle);
		list_cmd_t c;
		c.cmd = cmd;
		c.position = plal_pkg::POS_W'(position);
		c.value = value;
		c.wait_idle = wait_idle;
		queued_cmds.push_back(c);
		case (cmd)
			plal_pkg::CMD_CLEAR: gen_len = 0;
			plal_pkg::CMD_APPEND: if (gen_len < LIST_DEPTH) gen_len++;
			plal_pkg::CMD_INSERT:
				if (gen_len < LIST_DEPTH && c.position >= 1 && c.position <= gen_len + 1)
					gen_len++;
			plal_pkg::CMD_DELETE: if (c.position >= 1 && c.position <= gen_len) gen_len--;
			default: ;
		endcase
		if (cmd == plal_pkg::CMD_APPEND || cmd == plal_pkg::CMD_INSERT) begin
			recent_values.push_back(value);
			if (recent_values.size() > 12) void'(recent_values.pop_front());
		end
	endfunction

	// command mix per traffic shape
	function automatic logic [plal_pkg::CMD_W-1:0] pick_cmd(int mode);
		int roll;
		int cut_app, cut_ins, cut_del, cut_srch, cut_rd, cut_spare;
		roll = $urandom_range(0, 99);
		case (mode)
			MODE_GROW:   begin cut_app = 35; cut_ins = 70; cut_del = 78; cut_srch = 88;
				cut_rd = 98; cut_spare = 99; end
			MODE_SHRINK: begin cut_app = 5; cut_ins = 15; cut_del = 55; cut_srch = 75;
				cut_rd = 97; cut_spare = 99; end
			MODE_MIXED:  begin cut_app = 15; cut_ins = 30; cut_del = 45; cut_srch = 70;
				cut_rd = 95; cut_spare = 98; end
			default:     begin cut_app = 8; cut_ins = 16; cut_del = 24; cut_srch = 62;
				cut_rd = 97; cut_spare = 99; end
		endcase
		if (roll < cut_app) return plal_pkg::CMD_APPEND;
		if (roll < cut_ins) return plal_pkg::CMD_INSERT;
		if (roll < cut_del) return plal_pkg::CMD_DELETE;
		if (roll < cut_srch) return plal_pkg::CMD_SEARCH;
		if (roll < cut_rd) return plal_pkg::CMD_READ;
		if (roll < cut_spare) return $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
		return plal_pkg::CMD_CLEAR;
	endfunction

	// mostly in range, sometimes just outside or anywhere in the field
	function automatic int pick_position(logic [plal_pkg::CMD_W-1:0] cmd);
		int top;
		top = (cmd == plal_pkg::CMD_INSERT) ? gen_len + 1 : gen_len;
		if (top >= 1 && $urandom_range(0, 99) < 85) return $urandom_range(1, top);
		case ($urandom_range(0, 4))
			0: return 0;
			1: return top + 1;
			2: return LIST_DEPTH;
			3: return 127;
			default: return $urandom_range(0, 127);
		endcase
	endfunction

	function automatic logic [plal_pkg::VAL_W-1:0] pick_value(logic [plal_pkg::CMD_W-1:0] cmd);
		int roll;
		roll = $urandom_range(0, 99);
		if (recent_values.size() != 0 && roll < ((cmd == plal_pkg::CMD_SEARCH) ? 60 : 25))
			return recent_values[$urandom_range(0, recent_values.size() - 1)];
		if (roll < 45) begin
			case ($urandom_range(0, 4))
				0: return 32'h0000_0000;
				1: return 32'hFFFF_FFFF;
				2: return 32'h7FFF_FFFF;
				3: return 32'h8000_0000;
				default: return $urandom_range(0, 3);
			endcase
		end
		return $urandom;
	endfunction

	// extremes and the range and spare-code cases on a short list
	task automatic queue_directed();
		queue_cmd(plal_pkg::CMD_READ,   1,   32'h0, 1'b0);
		queue_cmd(plal_pkg::CMD_DELETE, 1,   32'h0, 1'b0);
		queue_cmd(plal_pkg::CMD_SEARCH, 0,   32'h0, 1'b0);
		queue_cmd(plal_pkg::CMD_INSERT, 0,   32'h1, 1'b0);
		queue_cmd(plal_pkg::CMD_INSERT, 2,   32'h2, 1'b0);
		queue_cmd(plal_pkg::CMD_APPEND, 0,   32'h7FFF_FFFF, 1'b0);
		queue_cmd(plal_pkg::CMD_APPEND, 127, 32'h8000_0000, 1'b0);
		queue_cmd(plal_pkg::CMD_INSERT, 1,   32'hFFFF_FFFF, 1'b0);
		queue_cmd(plal_pkg::CMD_INSERT, 4,   32'h0, 1'b0);
		queue_cmd(plal_pkg::CMD_INSERT, 2,   32'h5555_5555, 1'b0);
		queue_cmd(plal_pkg::CMD_APPEND, 0,   32'hAAAA_AAAA, 1'b0);
		queue_cmd(plal_pkg::CMD_SEARCH, 0,   32'h8000_0000, 1'b0);
		queue_cmd(plal_pkg::CMD_SEARCH, 127, 32'h1234_5678, 1'b0);
		queue_cmd(plal_pkg::CMD_READ,   0,   32'h0, 1'b0);
		queue_cmd(plal_pkg::CMD_READ,   6,   32'h0, 1'b0);
		queue_cmd(plal_pkg::CMD_READ,   127, 32'h0, 1'b0);
		queue_cmd(plal_pkg::CMD_DELETE, 127, 32'h0, 1'b0);
		queue_cmd(plal_pkg::CMD_DELETE, 6,   32'h0, 1'b0);
		queue_cmd(plal_pkg::CMD_DELETE, 1,   32'h0, 1'b0);
		queue_cmd(CMD_SPARE_6, 64, 32'hFFFF_FFFF, 1'b0);
		queue_cmd(CMD_SPARE_7, 1,  32'h0, 1'b0);
		queue_cmd(plal_pkg::CMD_SEARCH, 0,   32'hFFFF_FFFF, 1'b0);
		queue_cmd(plal_pkg::CMD_CLEAR,  0,   32'h0, 1'b0);
		queue_cmd(plal_pkg::CMD_SEARCH, 0,   32'h7FFF_FFFF, 1'b0);
		queue_cmd(plal_pkg::CMD_READ,   1,   32'h0, 1'b0);
	endtask

	// episodes of one traffic shape each, some starting from an idle block
	task automatic queue_random(int n);
		int made, left, mode;
		bit idle_first;
		logic [plal_pkg::CMD_W-1:0] cmd;
		made = 0;
		while (made < n) begin
			mode = $urandom_range(MODE_GROW, MODE_QUERY);
			left = $urandom_range(40, 160);
			idle_first = (made == 0) || ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 3) == 0) begin
				queue_cmd(plal_pkg::CMD_CLEAR, $urandom_range(0, 127), $urandom, idle_first);
				idle_first = 1'b0;
				made++;
			end
			while (left > 0 && made < n) begin
				cmd = pick_cmd(mode);
				queue_cmd(cmd, pick_position(cmd), pick_value(cmd), idle_first);
				idle_first = 1'b0;
				left--;
				made++;
			end
		end
	endtask

	// sender: bursts of words with random gaps
	always @(negedge clk) begin : drive_words
		logic      next_valid;
		list_cmd_t c;
		next_valid = s_tvalid;
		if (s_tvalid && words_in != words_seen) begin
			words_seen = words_in;
			next_valid = 1'b0;
		end
		if (arst_n && !next_valid) begin
			if (gap_left != 0) gap_left--;
			else if (queued_cmds.size() != 0 &&
					!(queued_cmds[0].wait_idle && predicted_replies.size() != 0)) begin
				c = queued_cmds.pop_front();
				s_tdata <= {1'b0, c.value, c.position};
				s_tuser <= c.cmd;
				next_valid = 1'b1;
				if (burst_left != 0) burst_left--;
				else begin
					burst_left = $urandom_range(1, 48);
					gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
				end
			end
		end
		s_tvalid <= next_valid;
	end

	// receiver: stall pattern per segment, plus one long hold-off
	always @(negedge clk) begin : drive_ready
		if (!arst_n) m_tready <= 1'b0;
		else if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!hold_done && words_in >= HOLD_AT_WORD) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			if (segment_left == 0) begin
				ready_mode = $urandom_range(RDY_ALWAYS, RDY_DENSE);
				segment_left = $urandom_range(16, 160);
			end
			segment_left--;
			case (ready_mode)
				RDY_ALWAYS: m_tready <= 1'b1;
				RDY_HALF:   m_tready <= $urandom_range(0, 1);
				RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:    m_tready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// predict on each accepted word, check each delivered word
	always @(posedge clk) begin : check_words
		list_reply_t want, got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predicted_replies.push_back(apply_list_cmd(s_tuser, s_tdata[6:0],
					s_tdata[38:7]));
				words_in++;
			end
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[1:0];
				got.found = m_tdata[2];
				got.found_position = m_tdata[9:3];
				got.read_value = m_tdata[41:10];
				got.count = m_tdata[48:42];
				if (predicted_replies.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: result word with nothing pending: %h", $time, m_tdata);
				end else begin
					want = predicted_replies.pop_front();
					if (got.status !== want.status || got.found !== want.found ||
							got.found_position !== want.found_position ||
							got.read_value !== want.read_value || got.count !== want.count) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS) begin
							$write("%0t: mismatch status %0d/%0d found %0d/%0d pos %0d/%0d ",
								$time, want.status, got.status, want.found, got.found,
								want.found_position, got.found_position);
							$display("value %h/%h count %0d/%0d (expected/actual)",
								want.read_value, got.read_value, want.count, got.count);
						end
					end
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : run_test
		int total_words;
		queue_directed();
		queue_random(RANDOM_WORDS);
		total_words = queued_cmds.size();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait (words_in == total_words);
		wait (predicted_replies.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && predicted_replies.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/plal_pkg.sv
hdl/plal_cell.sv
hdl/positional_array_list.sv
dv/positional_array_list_test.sv
